// ===== design/lcs_pkg.sv =====
// lcs_pkg: shared constants, types and command codes of the lcs length engine
// depends on nothing; imported by every module of the engine
package lcs_pkg;

	localparam int MAX_LEN     = 64;
	localparam int SYMBOL_BITS = 8;

	// field widths fixed by the interface
	localparam int CMD_W    = 2;
	localparam int SYMBOL_W = 8;
	localparam int LEN_W    = 7;

	// derived widths
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	typedef logic [CMD_W-1:0]       cmd_t;
	typedef logic [SYMBOL_BITS-1:0] sym_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam cmd_t CMD_LOAD_FIRST  = 2'd0;
	localparam cmd_t CMD_LOAD_SECOND = 2'd1;
	localparam cmd_t CMD_COMPUTE     = 2'd2;

	// control from the sequencer to the symbol store
	typedef struct packed {
		logic load_first;
		logic load_second;
		logic clear;
	} store_ctl_t;

	// status from the symbol store
	typedef struct packed {
		cnt_t first_count;
		cnt_t second_count;
		logic dropped;
	} store_sts_t;

endpackage

// ===== design/lcs_length_engine_core.sv =====
// lcs_length_engine_core: top level, request decode, table sequencer and cell update
// instantiates lcs_symbol_store and lcs_score_row; uses lcs_pkg

// Requests carry cmd and symbol. A load request (first or second string) gives no
// result; a load into a store that already holds MAX_LEN symbols is dropped and
// sets the overflow flag of the next result. A compute request gives one result:
// the longest-common-subsequence length of the two loaded strings and the overflow
// flag, after which both strings and the flag are cleared. Code 3 is ignored. The
// table is built one row at a time in a single score-row memory, one cell per
// cycle through its read-modify-write path, after a row-fetch state that reads
// that row's first-string symbol; a compute with an empty string skips the table
// and goes straight to the result. No request is taken while the table is built
// or while a finished result waits for a free output register.
module lcs_length_engine_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lcs_pkg::cmd_t        cmd,
	input  logic [lcs_pkg::SYMBOL_W-1:0] symbol,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [lcs_pkg::LEN_W-1:0] lcs_length,
	output logic                 overflow
);
	import lcs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_CELL,
		S_DRAIN,
		S_OUT
	} state_t;

	state_t state_q;

	// request acceptance
	logic       in_fire;
	store_ctl_t store_ctl;
	store_sts_t store_sts;

	// table walk
	cnt_t m_q;          // rows, first string length
	cnt_t n_q;          // columns, second string length
	idx_t i_q;          // current row
	idx_t j_q;          // column being issued to the memories
	logic row_last;
	logic col_last;
	logic ov_q;
	cnt_t res_q;

	// memory read data
	sym_t a_sym;
	sym_t b_sym;
	cnt_t up_raw;

	// cell stage, in the cycle after the issue
	logic v_s1;
	idx_t j_s1;
	logic first_row_s1;
	logic last_s1;
	cnt_t left_q;
	cnt_t diag_q;
	cnt_t up_val;
	cnt_t left_val;
	cnt_t diag_val;
	cnt_t cell_val;

	// output register
	logic             out_valid_q;
	logic [LEN_W-1:0] lcs_length_q;
	logic             overflow_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		store_ctl             = '0;
		store_ctl.load_first  = in_fire && (cmd == CMD_LOAD_FIRST);
		store_ctl.load_second = in_fire && (cmd == CMD_LOAD_SECOND);
		// counts and flag are snapshotted at the compute request, then cleared
		store_ctl.clear       = in_fire && (cmd == CMD_COMPUTE);
	end

	lcs_symbol_store u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (store_ctl),
		.wr_sym         (symbol[SYMBOL_BITS-1:0]),
		.rd_first_en    (state_q == S_ROW),
		.rd_first_addr  (i_q),
		.rd_first_data  (a_sym),
		.rd_second_en   (state_q == S_CELL),
		.rd_second_addr (j_q),
		.rd_second_data (b_sym),
		.sts            (store_sts)
	);

	// column j+1 is read while the cell stage writes column j, so the two never
	// collide; the row fetch cycle keeps a row's first read behind the last write
	// of the row before
	lcs_score_row u_row (
		.clk     (clk),
		.wr_en   (v_s1),
		.wr_addr (j_s1),
		.wr_data (cell_val),
		.rd_en   (state_q == S_CELL),
		.rd_addr (j_q),
		.rd_data (up_raw)
	);

	assign row_last = (CNT_W'(i_q) + CNT_W'(1)) == m_q;
	assign col_last = (CNT_W'(j_q) + CNT_W'(1)) == n_q;

	// cell update: border is zero on the first row and the first column
	always_comb begin
		up_val   = first_row_s1 ? '0 : up_raw;
		left_val = (j_s1 == '0) ? '0 : left_q;
		diag_val = (j_s1 == '0) ? '0 : diag_q;
		if (a_sym == b_sym) begin
			cell_val = diag_val + CNT_W'(1);
		end else begin
			cell_val = (up_val > left_val) ? up_val : left_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_CELL);
		end
	end

	always_ff @(posedge clk) begin
		j_s1         <= j_q;
		first_row_s1 <= (i_q == '0);
		last_s1      <= row_last && col_last;
		if (v_s1) begin
			left_q <= cell_val;
			diag_q <= up_val;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_q          <= '0;
			n_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			ov_q         <= 1'b0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			lcs_length_q <= '0;
			overflow_q   <= 1'b0;
		end else begin
			// in S_OUT the output register is handled by the state itself
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (v_s1 && last_s1) begin
				res_q <= cell_val;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (cmd == CMD_COMPUTE)) begin
						m_q  <= store_sts.first_count;
						n_q  <= store_sts.second_count;
						ov_q <= store_sts.dropped;
						i_q  <= '0;
						if ((store_sts.first_count == '0) || (store_sts.second_count == '0)) begin
							res_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_ROW;
						end
					end
				end
				S_ROW: begin
					j_q     <= '0;
					state_q <= S_CELL;
				end
				S_CELL: begin
					if (col_last) begin
						if (row_last) begin
							state_q <= S_DRAIN;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= S_ROW;
						end
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						lcs_length_q <= LEN_W'(res_q);
						overflow_q   <= ov_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign lcs_length = lcs_length_q;
	assign overflow   = overflow_q;

endmodule

// ===== design/lcs_symbol_store.sv =====
// lcs_symbol_store: the two symbol string memories, their fill counts and the
// dropped-load flag; depends on lcs_pkg
module lcs_symbol_store (
	input  logic               clk,
	input  logic               arst_n,
	input  lcs_pkg::store_ctl_t ctl,
	input  lcs_pkg::sym_t      wr_sym,
	input  logic               rd_first_en,
	input  lcs_pkg::idx_t      rd_first_addr,
	output lcs_pkg::sym_t      rd_first_data,
	input  logic               rd_second_en,
	input  lcs_pkg::idx_t      rd_second_addr,
	output lcs_pkg::sym_t      rd_second_data,
	output lcs_pkg::store_sts_t sts
);
	import lcs_pkg::*;

	sym_t first_mem  [MAX_LEN];
	sym_t second_mem [MAX_LEN];

	cnt_t first_count_q;
	cnt_t second_count_q;
	logic dropped_q;
	logic first_room;
	logic second_room;

	assign first_room  = first_count_q < CNT_W'(MAX_LEN);
	assign second_room = second_count_q < CNT_W'(MAX_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			dropped_q      <= 1'b0;
		end else if (ctl.clear) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			dropped_q      <= 1'b0;
		end else if (ctl.load_first) begin
			if (first_room) begin
				first_count_q <= first_count_q + CNT_W'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end else if (ctl.load_second) begin
			if (second_room) begin
				second_count_q <= second_count_q + CNT_W'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_first && first_room) begin
			first_mem[first_count_q[IDX_W-1:0]] <= wr_sym;
		end
		if (rd_first_en) begin
			rd_first_data <= first_mem[rd_first_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_second && second_room) begin
			second_mem[second_count_q[IDX_W-1:0]] <= wr_sym;
		end
		if (rd_second_en) begin
			rd_second_data <= second_mem[rd_second_addr];
		end
	end

	assign sts.first_count  = first_count_q;
	assign sts.second_count = second_count_q;
	assign sts.dropped      = dropped_q;

endmodule

// ===== design/lcs_score_row.sv =====
// lcs_score_row: working row of the lcs table, one write and one read port
// entry k holds column k+1; column zero is the constant border. uses lcs_pkg
module lcs_score_row (
	input  logic          clk,
	input  logic          wr_en,
	input  lcs_pkg::idx_t wr_addr,
	input  lcs_pkg::cnt_t wr_data,
	input  logic          rd_en,
	input  lcs_pkg::idx_t rd_addr,
	output lcs_pkg::cnt_t rd_data
);
	import lcs_pkg::*;

	cnt_t row_mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= row_mem[rd_addr];
		end
	end

endmodule
